// File: sv/itag_pkg.sv
`timescale 1ns / 1ps

package itag_pkg;

    localparam int AW          = 48;
    localparam int LW          = 5;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int TABLE_DEPTH = 17;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
    localparam int GB_SHIFT    = 30;
    localparam int RADIX_LOG2  = 3;

    localparam logic [1:0] CMD_TREE_PARENT = 2'd0;
    localparam logic [1:0] CMD_COUNTER     = 2'd1;
    localparam logic [1:0] CMD_HASH        = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_GB = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_GB  = 1'd1;

    typedef enum logic [1:0] {
        ST_ROUND,
        ST_TREE,
        ST_FILL,
        ST_RUN
    } t_build_state;

    typedef struct packed {
        logic                 en;
        logic [TBL_IDX_W-1:0] idx;
        logic [AW-1:0]        data;
    } t_tbl_wr;

    typedef struct packed {
        logic          ready;
        logic [LW-1:0] leaf_lvl;
        logic [AW-1:0] base0;
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
    } t_tbl_info;

endpackage

// File: sv/itag_if.sv
`timescale 1ns / 1ps

interface itag_in_if
    import itag_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [1:0]    command;
    logic [AW-1:0] lookup_addr;
    logic [LW-1:0] addr_level;

    modport source (output valid, output command, output lookup_addr, output addr_level,
                    input ready);
    modport sink (input valid, input command, input lookup_addr, input addr_level,
                  output ready);
endinterface

interface itag_out_if
    import itag_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [AW-1:0] result_addr;
    logic [LW-1:0] result_level;
    logic [LW-1:0] data_level_now;
    logic          range_error;

    modport source (output valid, output result_addr, output result_level,
                    output data_level_now, output range_error, input ready);
    modport sink (input valid, input result_addr, input result_level,
                  input data_level_now, input range_error, output ready);
endinterface

// File: sv/itag_builder.sv
`timescale 1ns / 1ps

module itag_builder
    import itag_pkg::*;
#(
    parameter int LBB        = 6,
    parameter int LTA        = 3,
    parameter int LCA        = 6,
    parameter int LHB        = 3,
    parameter int MAX_LEVELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_tbl_wr              o_wr,
    output t_tbl_info            o_info
);

    localparam logic [AW-1:0] N_INIT = AW'(1) << (2 * RADIX_LOG2);

    t_build_state r_state, n_state;
    logic [CFG_W-1:0] r_mem_gb, r_start_gb;
    logic [AW-1:0]    r_n, n_n;
    logic [AW-1:0]    r_num, n_num;
    logic [AW-1:0]    r_acc, n_acc;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [LW-1:0]    r_t, n_t;
    logic [LW-1:0]    r_dl, n_dl;
    logic [LW-1:0]    r_idx, n_idx;

    logic [AW-1:0] size, start, lo, hi, blocks, last, cnt_div;
    logic          tree_more;

    assign size      = AW'(r_mem_gb) << GB_SHIFT;
    assign start     = AW'(r_start_gb) << GB_SHIFT;
    assign lo        = start + size;
    assign hi        = lo + size;
    assign blocks    = size >> LBB;
    assign last      = r_n >> LCA;
    assign cnt_div   = r_cnt >> LTA;
    assign tree_more = (r_num < last) && ((r_t + LW'(2)) < LW'(MAX_LEVELS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ROUND: begin
                if (r_n >= blocks) n_state = ST_TREE;
            end
            ST_TREE: begin
                if (!tree_more) n_state = ST_FILL;
            end
            ST_FILL: begin
                if (r_idx == LW'(1)) n_state = ST_RUN;
            end
            ST_RUN: n_state = ST_RUN;
            default: n_state = ST_ROUND;
        endcase
        if (i_cfg_we) n_state = ST_ROUND;
    end

    always_comb begin
        n_n     = r_n;
        n_num   = r_num;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_t     = r_t;
        n_dl    = r_dl;
        n_idx   = r_idx;
        o_wr    = '0;
        case (r_state)
            ST_ROUND: begin
                if (r_n < blocks) begin
                    n_n = r_n << RADIX_LOG2;
                end else begin
                    n_t   = '0;
                    n_num = AW'(1);
                end
            end
            ST_TREE: begin
                if (tree_more) begin
                    n_t   = r_t + LW'(1);
                    n_num = r_num << LTA;
                end else begin
                    n_dl  = r_t + LW'(2);
                    n_idx = r_t + LW'(2);
                end
            end
            ST_FILL: begin
                o_wr.en  = 1'b1;
                o_wr.idx = r_idx[TBL_IDX_W-1:0];
                n_idx    = r_idx - LW'(1);
                if (r_idx == r_dl) begin
                    o_wr.data = start;
                    n_acc     = lo + (r_n << LHB);
                    n_cnt     = last;
                end else begin
                    o_wr.data = r_acc;
                    n_acc     = r_acc + (r_cnt << LBB);
                    n_cnt     = (cnt_div == '0) ? AW'(1) : cnt_div;
                end
            end
            default: ;
        endcase
        if (i_cfg_we) n_n = N_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ROUND;
            r_mem_gb   <= CFG_W'(1);
            r_start_gb <= '0;
            r_n        <= N_INIT;
            r_dl       <= LW'(2);
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_dl    <= n_dl;
            if (i_cfg_we && i_cfg_idx == REG_MEMORY_GB) r_mem_gb <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_START_GB) r_start_gb <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_t   <= n_t;
        r_idx <= n_idx;
    end

    assign o_info.ready    = (r_state == ST_RUN);
    assign o_info.leaf_lvl = r_dl;
    assign o_info.base0    = lo;
    assign o_info.lo       = lo;
    assign o_info.hi       = hi;

    a_dl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dl >= LW'(2)) && (r_dl <= LW'(MAX_LEVELS)))
        else $error("data level out of range");

    a_wr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (o_wr.idx >= TBL_IDX_W'(1)) && (LW'(o_wr.idx) <= r_dl))
        else $error("table write outside built levels");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && !i_cfg_we |=> (r_state == ST_RUN))
        else $error("table left run without a register write");

endmodule

// File: sv/itag_lookup.sv
`timescale 1ns / 1ps

module itag_lookup
    import itag_pkg::*;
#(
    parameter int LBB = 6,
    parameter int LTA = 3,
    parameter int LCA = 6,
    parameter int LHB = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tbl_wr    i_wr,
    input  t_tbl_info  i_info,
    itag_in_if.sink    i_item,
    itag_out_if.source o_result
);

    localparam int HSH = (LBB > LHB) ? (LBB - LHB) : 0;

    logic [AW-1:0] mem [TABLE_DEPTH];

    logic          r_s_valid;
    logic [1:0]    r_s_cmd;
    logic [AW-1:0] r_s_addr;
    logic [LW-1:0] r_s_lvl;
    logic [AW-1:0] r_rd_cur, r_rd_par;

    logic          r_o_valid;
    logic [AW-1:0] r_o_addr;
    logic [LW-1:0] r_o_level;
    logic [LW-1:0] r_o_dl;
    logic          r_o_err;

    logic out_en, s_en, load;
    logic [TBL_IDX_W-1:0] a_cur, a_par;

    logic [AW-1:0] base_cur, base_par, diff, blk, par, span, hash_res, par_res;
    logic [AW-1:0] res;
    logic [LW-1:0] rlvl;
    logic          err, ok_hash, ok_par, is_hash, is_par;

    assign out_en       = !r_o_valid || o_result.ready;
    assign s_en         = !r_s_valid || out_en;
    assign i_item.ready = s_en && i_info.ready;
    assign load         = i_item.valid && i_item.ready;

    assign a_cur = (i_item.addr_level <= LW'(TABLE_DEPTH - 1)) ?
                   i_item.addr_level[TBL_IDX_W-1:0] : '0;
    assign a_par = ((i_item.addr_level >= LW'(1)) &&
                    (i_item.addr_level <= LW'(TABLE_DEPTH - 1))) ?
                   TBL_IDX_W'(i_item.addr_level - LW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) mem[i_wr.idx] <= i_wr.data;
        if (load) begin
            r_rd_cur <= mem[a_cur];
            r_rd_par <= mem[a_par];
            r_s_cmd  <= i_item.command;
            r_s_addr <= i_item.lookup_addr;
            r_s_lvl  <= i_item.addr_level;
        end
    end

    always_comb begin
        base_cur = (r_s_lvl == '0) ? i_info.base0 : r_rd_cur;
        base_par = (r_s_lvl == LW'(1)) ? i_info.base0 : r_rd_par;
        diff     = r_s_addr - base_cur;
        blk      = diff >> LBB;
        hash_res = i_info.base0 + ((blk >> HSH) << LBB);
        par      = (r_s_cmd == CMD_COUNTER) ? (blk >> LCA) : (blk >> LTA);
        span     = (base_par - base_cur) >> LBB;
        par_res  = base_par + (par << LBB);
        is_hash  = (r_s_cmd == CMD_HASH);
        is_par   = (r_s_cmd == CMD_TREE_PARENT) || (r_s_cmd == CMD_COUNTER);
        ok_hash  = r_s_lvl <= i_info.leaf_lvl;
        ok_par   = (r_s_lvl >= LW'(1)) && ok_hash;
        res      = '0;
        rlvl     = '0;
        err      = 1'b1;
        if (is_hash && ok_hash) begin
            res = hash_res;
            err = (hash_res < i_info.lo) || (hash_res >= i_info.hi);
        end else if (is_par && ok_par) begin
            res  = par_res;
            rlvl = r_s_lvl - LW'(1);
            err  = (par >= span) || (par_res == r_s_addr) ||
                   (par_res < i_info.lo) || (par_res >= i_info.hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_en) r_s_valid <= load;
            if (out_en) r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s_valid) begin
            r_o_addr  <= res;
            r_o_level <= rlvl;
            r_o_dl    <= i_info.leaf_lvl;
            r_o_err   <= err;
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.result_addr    = r_o_addr;
    assign o_result.result_level   = r_o_level;
    assign o_result.data_level_now = r_o_dl;
    assign o_result.range_error    = r_o_err;

    a_level_below_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_err |-> (r_o_level < r_o_dl))
        else $error("clean result above data level");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !out_en |=> r_s_valid && $stable(r_s_addr))
        else $error("lookup stage dropped a stalled transaction");

    a_no_accept_building: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_info.ready |-> !load && !i_wr.en || !load)
        else $error("transaction accepted while table is built");

endmodule

// File: sv/integrity_tree_address_generator_core.sv
`timescale 1ns / 1ps

// integrity tree address generator
// i_item carries a command, a byte address and its level; o_result returns the
// parent, counter or hash block address, its level, the current data level and
// a range error flag. both are valid/ready channels; a transaction moves when
// valid and ready are high at a clock edge.
// registers memory_gb (index 0) and start_gb (index 1) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
// transaction is in flight, which the block does not enforce. after reset and
// after every register write a small sequencer rebuilds the level table by
// rounding the block count up, tree level counting, then one table write per
// level down to level 1; i_item.ready stays low meanwhile. a transaction goes
// through the registered two-port level table read, then the address
// arithmetic into the output register. throughput is one transaction per cycle
// while the table is built and results are taken; a stalled result waits in
// the output register while one more transaction is taken into the read stage.
module integrity_tree_address_generator_core
    import itag_pkg::*;
#(
    parameter int BLOCK_BYTES   = 64,
    parameter int TREE_ARITY    = 8,
    parameter int COUNTER_ARITY = 64,
    parameter int HASH_BYTES    = 8,
    parameter int MAX_LEVELS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    itag_in_if.sink              i_item,
    itag_out_if.source           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LBB = $clog2(BLOCK_BYTES);
    localparam int LTA = $clog2(TREE_ARITY);
    localparam int LCA = $clog2(COUNTER_ARITY);
    localparam int LHB = $clog2(HASH_BYTES);

    t_tbl_wr   tbl_wr;
    t_tbl_info tbl_info;

    itag_builder #(
        .LBB        (LBB),
        .LTA        (LTA),
        .LCA        (LCA),
        .LHB        (LHB),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_wr       (tbl_wr),
        .o_info     (tbl_info)
    );

    itag_lookup #(
        .LBB (LBB),
        .LTA (LTA),
        .LCA (LCA),
        .LHB (LHB)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .i_info   (tbl_info),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

// File: dv/itag_lookup_checker.sv
`timescale 1ns / 1ps

module itag_lookup_checker
    import itag_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    itag_in_if                   i_item,
    itag_out_if                  i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [AW-1:0]        o_level_base [TABLE_DEPTH],
    output logic [LW-1:0]        o_leaf_lvl,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int BLOCK_BYTES     = 64;
    localparam int TREE_ARITY      = 8;
    localparam int COUNTER_ARITY   = 64;
    localparam int HASH_BYTES      = 8;
    localparam int MAX_LEVELS      = 16;
    localparam int ROUND_RADIX     = 8;
    localparam int RESET_MEMORY_GB = 1;
    localparam int RESET_START_GB  = 0;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [LW-1:0] level;
        logic [LW-1:0] leaf_lvl;
        logic          err;
    } t_meta_result;

    logic [CFG_W-1:0] mem_size_gb;
    logic [CFG_W-1:0] region_start_gb;
    logic [AW-1:0]    base_of_level [TABLE_DEPTH];
    logic [LW-1:0]    data_depth;
    t_meta_result     meta_results_due [$];
    int               mismatch_count;

    function automatic void rebuild_bases();
        longint unsigned size_b;
        longint unsigned start_b;
        longint unsigned rounded;
        longint unsigned top_blocks;
        longint unsigned reach;
        int              tiers;
        int              depth;
        size_b  = 64'(mem_size_gb) << GB_SHIFT;
        start_b = 64'(region_start_gb) << GB_SHIFT;
        rounded = 64'(ROUND_RADIX * ROUND_RADIX);
        while (rounded < size_b / BLOCK_BYTES) rounded = rounded * ROUND_RADIX;
        top_blocks = rounded / COUNTER_ARITY;
        tiers = 0;
        reach = 1;
        while (reach < top_blocks && tiers + 2 < MAX_LEVELS) begin
            tiers++;
            reach = reach * TREE_ARITY;
        end
        depth      = tiers + 2;
        data_depth = LW'(depth);
        foreach (base_of_level[i]) base_of_level[i] = '0;
        base_of_level[0]       = AW'(start_b + size_b);
        base_of_level[depth]   = AW'(start_b);
        base_of_level[depth-1] = base_of_level[0] + AW'(rounded * HASH_BYTES);
        reach = top_blocks;
        for (int i = depth - 2; i > 0; i--) begin
            base_of_level[i] = base_of_level[i+1] + AW'(reach * BLOCK_BYTES);
            reach = reach / TREE_ARITY;
            if (reach == 0) reach = 1;
        end
    endfunction

    function automatic t_meta_result predict_lookup(input logic [1:0]    cmd,
                                                    input logic [AW-1:0] addr,
                                                    input logic [LW-1:0] lvl);
        t_meta_result    r;
        logic [AW-1:0]   diff;
        logic [AW-1:0]   blk;
        logic [AW-1:0]   parent;
        logic [AW-1:0]   span;
        longint unsigned lo;
        longint unsigned hi;
        lo = (64'(region_start_gb) << GB_SHIFT) + (64'(mem_size_gb) << GB_SHIFT);
        hi = lo + (64'(mem_size_gb) << GB_SHIFT);
        r.addr     = '0;
        r.level    = '0;
        r.leaf_lvl = data_depth;
        r.err      = 1'b1;
        if (cmd == CMD_HASH && lvl <= data_depth) begin
            diff   = addr - base_of_level[lvl];
            blk    = diff / BLOCK_BYTES;
            r.addr = base_of_level[0] + (blk / (BLOCK_BYTES / HASH_BYTES)) * BLOCK_BYTES;
            r.err  = 64'(r.addr) < lo || 64'(r.addr) >= hi;
        end else if ((cmd == CMD_TREE_PARENT || cmd == CMD_COUNTER)
                     && lvl >= 1 && lvl <= data_depth) begin
            diff    = addr - base_of_level[lvl];
            blk     = diff / BLOCK_BYTES;
            parent  = blk / ((cmd == CMD_COUNTER) ? COUNTER_ARITY : TREE_ARITY);
            diff    = base_of_level[lvl-1] - base_of_level[lvl];
            span    = diff / BLOCK_BYTES;
            r.addr  = base_of_level[lvl-1] + parent * BLOCK_BYTES;
            r.level = lvl - LW'(1);
            r.err   = parent >= span || r.addr == addr
                      || 64'(r.addr) < lo || 64'(r.addr) >= hi;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_meta_result want;
        if (!i_rst_n) begin
            mem_size_gb     = CFG_W'(RESET_MEMORY_GB);
            region_start_gb = CFG_W'(RESET_START_GB);
            rebuild_bases();
            meta_results_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MEMORY_GB) mem_size_gb = i_cfg_data;
                else region_start_gb = i_cfg_data;
                rebuild_bases();
            end
            if (i_result.valid && i_result.ready) begin
                if (meta_results_due.size() == 0) begin
                    $error("unexpected result transaction: result_addr %h", i_result.result_addr);
                    mismatch_count++;
                end else begin
                    want = meta_results_due[0];
                    meta_results_due.delete(0);
                    if (i_result.result_addr !== want.addr) begin
                        $error("result_addr: expected %h, got %h",
                               want.addr, i_result.result_addr);
                        mismatch_count++;
                    end
                    if (i_result.result_level !== want.level) begin
                        $error("result_level: expected %0d, got %0d",
                               want.level, i_result.result_level);
                        mismatch_count++;
                    end
                    if (i_result.data_level_now !== want.leaf_lvl) begin
                        $error("data_level_now: expected %0d, got %0d",
                               want.leaf_lvl, i_result.data_level_now);
                        mismatch_count++;
                    end
                    if (i_result.range_error !== want.err) begin
                        $error("range_error: expected %b, got %b",
                               want.err, i_result.range_error);
                        mismatch_count++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                meta_results_due = {meta_results_due,
                                    predict_lookup(i_item.command, i_item.lookup_addr,
                                                   i_item.addr_level)};
            end
        end
        o_pending    <= meta_results_due.size();
        o_fail_count <= mismatch_count;
        o_level_base <= base_of_level;
        o_leaf_lvl   <= data_depth;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import itag_pkg::*;

    localparam int         CLK_HALF_NS    = 6;
    localparam int         RESET_CYCLES   = 11;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PRESSURE_PHASE = 4;
    localparam int         NUM_PHASES     = 6;
    localparam logic [1:0] CMD_UNKNOWN    = 2'd3;

    typedef struct {
        int mem_gb;
        int start_gb;
        int src_idle;
        int sink_stall;
        int items;
    } t_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic [AW-1:0]        level_base [TABLE_DEPTH];
    logic [LW-1:0]        leaf_lvl;
    int                   pending;
    int                   mismatch_count;
    int                   src_idle_pct;
    int                   sink_stall_pct;
    int                   quiet_cycles;
    t_phase               phases [NUM_PHASES];

    itag_in_if  item_ch ();
    itag_out_if result_ch ();

    integrity_tree_address_generator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    itag_lookup_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_level_base (level_base),
        .o_leaf_lvl   (leaf_lvl),
        .o_pending    (pending),
        .o_fail_count (mismatch_count)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_lookup(input logic [1:0]    cmd,
                               input logic [AW-1:0] addr,
                               input logic [LW-1:0] lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.lookup_addr <= addr;
        item_ch.addr_level  <= lvl;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic send_random_lookup();
        logic [1:0]    cmd;
        logic [LW-1:0] lvl;
        logic [AW-1:0] addr;
        logic [AW-1:0] extent;
        int            dl;
        dl = int'(leaf_lvl);
        if ($urandom_range(99) < 15) begin
            cmd  = 2'($urandom_range(3));
            lvl  = LW'($urandom_range(31));
            addr = AW'({$urandom, $urandom});
        end else begin
            case ($urandom_range(2))
                0: cmd = CMD_TREE_PARENT;
                1: cmd = CMD_COUNTER;
                default: cmd = CMD_HASH;
            endcase
            if (cmd == CMD_HASH) lvl = LW'($urandom_range(dl, 0));
            else lvl = LW'($urandom_range(dl, 1));
            // level 0 lies below level 1 in the table, so level 1 has no upper bound there: keep to 64 blocks
            if (lvl == 0) extent = level_base[dl-1] - level_base[0];
            else if (lvl == 1) extent = AW'(4096);
            else extent = level_base[lvl-1] - level_base[lvl];
            if (extent == 0) extent = AW'(64);
            addr = level_base[lvl] + AW'({$urandom, $urandom} % extent);
        end
        send_lookup(cmd, addr, lvl);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
    endtask

    task automatic run_directed();
        int dl;
        dl = int'(leaf_lvl);
        send_lookup(CMD_TREE_PARENT, '0, LW'(dl));
        send_lookup(CMD_TREE_PARENT, level_base[0] - AW'(1), LW'(dl));
        send_lookup(CMD_COUNTER, level_base[dl] + AW'(48'h40_0040), LW'(dl));
        send_lookup(CMD_COUNTER, level_base[dl-1], LW'(dl - 1));
        send_lookup(CMD_HASH, '0, LW'(dl));
        send_lookup(CMD_HASH, level_base[0] - AW'(64), LW'(dl));
        send_lookup(CMD_HASH, level_base[0], '0);
        send_lookup(CMD_HASH, level_base[dl-1] + AW'(64), LW'(dl - 1));
        send_lookup(CMD_TREE_PARENT, level_base[2], LW'(2));
        send_lookup(CMD_TREE_PARENT, level_base[1], LW'(1));
        send_lookup(CMD_COUNTER, level_base[1], LW'(1));
        send_lookup(CMD_TREE_PARENT, level_base[0], '0);
        send_lookup(CMD_COUNTER, level_base[0], '0);
        send_lookup(CMD_UNKNOWN, level_base[dl], LW'(dl));
        send_lookup(CMD_UNKNOWN, '1, '1);
        send_lookup(CMD_TREE_PARENT, '0, LW'(dl + 1));
        send_lookup(CMD_HASH, '1, '1);
        send_lookup(CMD_COUNTER, '1, LW'(dl));
        send_lookup(CMD_TREE_PARENT, '0, LW'(dl - 1));
    endtask

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_TREE_PARENT;
        item_ch.lookup_addr = '0;
        item_ch.addr_level  = '0;
        cfg_we              = 1'b0;
        cfg_idx             = REG_MEMORY_GB;
        cfg_data            = '0;
        i_rst_n             = 1'b0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        quiet_cycles        = 0;

        phases[0] = '{1, 0, 0, 0, 250};
        phases[1] = '{64, 64, 85, 0, 250};
        phases[2] = '{127, 127, 0, 85, 250};
        phases[3] = '{0, 3, 26, 26, 100};
        phases[4] = '{13, 0, 0, 0, 300};
        phases[5] = '{int'($urandom_range(64, 1)), int'($urandom_range(64, 0)), 26, 26, 300};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct   = phases[p].src_idle;
            sink_stall_pct = phases[p].sink_stall;
            write_reg(REG_MEMORY_GB, CFG_W'(phases[p].mem_gb));
            write_reg(REG_START_GB, CFG_W'(phases[p].start_gb));
            @(negedge i_clk);
            cfg_we <= 1'b0;
            for (int n = 0; n < phases[p].items; n++) begin
                if (p == PRESSURE_PHASE && n == phases[p].items / 2) drain_results();
                send_random_lookup();
            end
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/itag_pkg.sv
sv/itag_if.sv
sv/itag_builder.sv
sv/itag_lookup.sv
sv/integrity_tree_address_generator_core.sv
dv/itag_lookup_checker.sv
dv/tb_top.sv
